### hdl/fbc_pkg.sv
package fbc_pkg;

    localparam int COEF_BITS  = 16;
    localparam int COORD_BITS = 24;
    localparam int COORD_FRAC = 8;

    localparam int PCOEF_BITS = COEF_BITS + 1;
    localparam int PROD_BITS  = PCOEF_BITS + COORD_BITS;
    localparam int ACC_BITS   = PROD_BITS + 2;

    localparam int NUM_ROWS   = 4;
    localparam int NUM_COLS   = 4;
    localparam int NUM_PLANES = 6;
    localparam int NUM_TERMS  = 4;
    localparam int ROW_BITS   = $clog2(NUM_ROWS);
    localparam int COL_BITS   = $clog2(NUM_COLS);
    localparam int PLANE_BITS = $clog2(NUM_PLANES);
    localparam int TERM_BITS  = $clog2(NUM_TERMS);

    typedef logic signed [COEF_BITS-1:0]  coef_t;
    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [PCOEF_BITS-1:0] pcoef_t;
    typedef logic signed [PROD_BITS-1:0]  prod_t;
    typedef logic signed [ACC_BITS-1:0]   acc_t;
    typedef logic [COL_BITS-1:0]          col_t;

    typedef enum logic [1:0] {
        ACT_LOAD  = 2'd0,
        ACT_POINT = 2'd1,
        ACT_BOX   = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    localparam logic [TERM_BITS-1:0]  TERM_X     = TERM_BITS'(0);
    localparam logic [TERM_BITS-1:0]  TERM_Y     = TERM_BITS'(1);
    localparam logic [TERM_BITS-1:0]  TERM_Z     = TERM_BITS'(2);
    localparam logic [TERM_BITS-1:0]  TERM_W     = TERM_BITS'(NUM_TERMS - 1);
    localparam logic [PLANE_BITS-1:0] PLANE_LAST = PLANE_BITS'(NUM_PLANES - 1);
    localparam logic [ROW_BITS-1:0]   ROW_W      = ROW_BITS'(NUM_ROWS - 1);

endpackage

### hdl/frustum_box_cull_core.sv
// Frustum culling engine. A load beat (action 0) writes one column of the
// 4x4 view-projection matrix in the cycle it is accepted and produces no
// result; action 3 is dropped the same way. A point test (action 1) or box
// test (action 2) runs the six clip planes through one shared multiply-add
// unit, one term per cycle (x, y, z products and the scaled w term), so a
// test holds cmd_stall high while it runs; its result beat appears on the
// cycle after the last term. The result sits in an output register; if it
// has not been taken when the next test finishes, that test waits on its
// last term until the register frees. The matrix resets to zero, so every
// test reports visible until columns are loaded.
module frustum_box_cull_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cmd_valid,
    output logic            cmd_stall,
    input  fbc_pkg::action_t action,
    input  fbc_pkg::col_t   column,
    input  fbc_pkg::coef_t  elem_row0,
    input  fbc_pkg::coef_t  elem_row1,
    input  fbc_pkg::coef_t  elem_row2,
    input  fbc_pkg::coef_t  elem_row3,
    input  fbc_pkg::coord_t lo_x,
    input  fbc_pkg::coord_t lo_y,
    input  fbc_pkg::coord_t lo_z,
    input  fbc_pkg::coord_t hi_x,
    input  fbc_pkg::coord_t hi_y,
    input  fbc_pkg::coord_t hi_z,
    output logic            res_valid,
    input  logic            res_stall,
    output logic            visible
);
    import fbc_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    state_t                  state_reg, state_next;
    coef_t                   mat_reg [NUM_ROWS][NUM_COLS];
    coord_t                  lo_reg [3], lo_next [3];
    coord_t                  hi_reg [3], hi_next [3];
    logic                    box_reg, box_next;
    logic [PLANE_BITS-1:0]   plane_reg, plane_next;
    logic [TERM_BITS-1:0]    term_reg, term_next;
    acc_t                    acc_reg, acc_next;
    logic                    pass_reg, pass_next;
    logic                    res_valid_reg, res_valid_next;
    logic                    visible_reg, visible_next;

    logic                    accept;
    logic                    res_free;
    logic [ROW_BITS-1:0]     row_sel;
    coef_t                   w_elem;
    coef_t                   r_elem;
    pcoef_t                  coef;
    coord_t                  lo_sel;
    coord_t                  hi_sel;
    coord_t                  coord_sel;
    prod_t                   prod;
    acc_t                    term_val;
    acc_t                    sum;
    logic                    plane_ok;

    assign accept    = cmd_valid && (state_reg == ST_IDLE);
    assign cmd_stall = (state_reg != ST_IDLE);
    assign res_valid = res_valid_reg;
    assign visible   = visible_reg;
    assign res_free  = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int r = 0; r < NUM_ROWS; r++)
            begin
                for (int c = 0; c < NUM_COLS; c++)
                begin
                    mat_reg[r][c] <= '0;
                end
            end
        end
        else if (accept && (action == ACT_LOAD))
        begin
            mat_reg[0][column] <= elem_row0;
            mat_reg[1][column] <= elem_row1;
            mat_reg[2][column] <= elem_row2;
            mat_reg[3][column] <= elem_row3;
        end
    end

    always_comb
    begin
        row_sel = plane_reg[PLANE_BITS-1:1];
        w_elem  = mat_reg[ROW_W][term_reg];
        r_elem  = mat_reg[row_sel][term_reg];
        if (plane_reg[0])
        begin
            coef = pcoef_t'(w_elem) - pcoef_t'(r_elem);
        end
        else
        begin
            coef = pcoef_t'(w_elem) + pcoef_t'(r_elem);
        end

        case (term_reg)
            TERM_X:
            begin
                lo_sel = lo_reg[0];
                hi_sel = hi_reg[0];
            end
            TERM_Y:
            begin
                lo_sel = lo_reg[1];
                hi_sel = hi_reg[1];
            end
            TERM_Z:
            begin
                lo_sel = lo_reg[2];
                hi_sel = hi_reg[2];
            end
            default:
            begin
                lo_sel = lo_reg[0];
                hi_sel = hi_reg[0];
            end
        endcase

        coord_sel = (box_reg && !coef[PCOEF_BITS-1]) ? hi_sel : lo_sel;
        prod      = prod_t'(coef) * prod_t'(coord_sel);

        if (term_reg == TERM_W)
        begin
            term_val = acc_t'(coef) <<< COORD_FRAC;
        end
        else
        begin
            term_val = acc_t'(prod);
        end

        sum      = acc_reg + term_val;
        plane_ok = !sum[ACC_BITS-1];
    end

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        box_next       = box_reg;
        plane_next     = plane_reg;
        term_next      = term_reg;
        acc_next       = acc_reg;
        pass_next      = pass_reg;
        res_valid_next = res_valid_reg;
        visible_next   = visible_reg;

        if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && ((action == ACT_POINT) || (action == ACT_BOX)))
                begin
                    state_next = ST_RUN;
                    lo_next[0] = lo_x;
                    lo_next[1] = lo_y;
                    lo_next[2] = lo_z;
                    hi_next[0] = hi_x;
                    hi_next[1] = hi_y;
                    hi_next[2] = hi_z;
                    box_next   = (action == ACT_BOX);
                    plane_next = '0;
                    term_next  = '0;
                    acc_next   = '0;
                    pass_next  = 1'b1;
                end
            end
            ST_RUN:
            begin
                if (term_reg != TERM_W)
                begin
                    acc_next  = sum;
                    term_next = term_reg + TERM_BITS'(1);
                end
                else if (plane_reg != PLANE_LAST)
                begin
                    acc_next   = '0;
                    pass_next  = pass_reg && plane_ok;
                    term_next  = '0;
                    plane_next = plane_reg + PLANE_BITS'(1);
                end
                else if (res_free)
                begin
                    acc_next       = '0;
                    state_next     = ST_IDLE;
                    res_valid_next = 1'b1;
                    visible_next   = pass_reg && plane_ok;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            box_reg       <= 1'b0;
            plane_reg     <= '0;
            term_reg      <= '0;
            acc_reg       <= '0;
            pass_reg      <= 1'b1;
            res_valid_reg <= 1'b0;
            visible_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            box_reg       <= box_next;
            plane_reg     <= plane_next;
            term_reg      <= term_next;
            acc_reg       <= acc_next;
            pass_reg      <= pass_next;
            res_valid_reg <= res_valid_next;
            visible_reg   <= visible_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
    end

endmodule

### hdl/fbc_checker.sv
module fbc_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            cmd_valid,
    input logic            cmd_stall,
    input fbc_pkg::action_t action,
    input logic            res_valid,
    input logic            res_stall,
    input logic            visible
);
    import fbc_pkg::*;

    a_test_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall && ((action == ACT_POINT) || (action == ACT_BOX)))
        |=> cmd_stall)
        else $error("test beat accepted but block did not go busy");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && !cmd_stall && !res_valid &&
         ((action == ACT_LOAD) || (action == ACT_NONE)))
        |=> !res_valid)
        else $error("result appeared after a beat that produces none");

    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(res_valid) |-> $past(cmd_stall))
        else $error("result appeared without a test in progress");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res_stall) |=> (res_valid && $stable(visible)))
        else $error("stalled result beat changed or dropped");

endmodule

bind frustum_box_cull_core fbc_checker u_fbc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .action    (action),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .visible   (visible)
);
